// ----- rtl/bc_alpha_block_decoder_macros.svh -----
// Assertion shorthands for the alpha block decoder checker.
`ifndef BC_ALPHA_BLOCK_DECODER_MACROS_SVH
`define BC_ALPHA_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcad: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BCAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcad: next-cycle check failed");

`endif

// ----- rtl/bcad_pkg.sv -----
package bcad_pkg;

    localparam int unsigned BLOCK_W = 64;
    localparam int unsigned TEXELS  = 16;

    localparam logic MODE_EXPLICIT = 1'b0;
    localparam logic MODE_INTERP   = 1'b1;
    localparam logic MODE_RESET    = MODE_INTERP;

    // floor(2^15 / 7) and floor(2^15 / 5); quotient is exact or one low
    localparam logic [12:0] DIV7_RECIP = 13'd4681;
    localparam logic [12:0] DIV5_RECIP = 13'd6553;
    localparam logic [2:0]  DIV7       = 3'd7;
    localparam logic [2:0]  DIV5       = 3'd5;

    localparam logic [7:0] ALPHA_MIN = 8'd0;
    localparam logic [7:0] ALPHA_MAX = 8'd255;

    typedef logic [7:0][7:0]  ramp_t;
    typedef logic [15:0][7:0] texels_t;

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] prod;
        logic [8:0]  q;
        logic [11:0] r;
        prod = 24'(x) * 24'(DIV7_RECIP);
        q    = prod[23:15];
        r    = 12'(x) - 12'(q) * 12'(DIV7);
        if (r >= 12'(DIV7))
        begin
            q = q + 9'd1;
        end
        return q[7:0];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] prod;
        logic [8:0]  q;
        logic [11:0] r;
        prod = 24'(x) * 24'(DIV5_RECIP);
        q    = prod[23:15];
        r    = 12'(x) - 12'(q) * 12'(DIV5);
        if (r >= 12'(DIV5))
        begin
            q = q + 9'd1;
        end
        return q[7:0];
    endfunction

    function automatic ramp_t build_ramp(input logic [7:0] a0, input logic [7:0] a1);
        ramp_t       ramp;
        logic [10:0] sum;
        ramp    = '0;
        ramp[0] = a0;
        ramp[1] = a1;
        if (a0 > a1)
        begin
            for (int i = 0; i < 6; i++)
            begin
                sum         = 11'(6 - i) * 11'(a0) + 11'(1 + i) * 11'(a1);
                ramp[2 + i] = div7(sum);
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                sum         = 11'(4 - i) * 11'(a0) + 11'(1 + i) * 11'(a1);
                ramp[2 + i] = div5(sum);
            end
            ramp[6] = ALPHA_MIN;
            ramp[7] = ALPHA_MAX;
        end
        return ramp;
    endfunction

endpackage

// ----- rtl/bcad_in_if.sv -----
interface bcad_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [bcad_pkg::BLOCK_W-1:0]          alpha_block;

    modport source (output valid, output alpha_block, input ready);
    modport sink   (input valid, input alpha_block, output ready);
endinterface

// ----- rtl/bcad_out_if.sv -----
interface bcad_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [bcad_pkg::BLOCK_W-1:0]          alpha_texels_low;
    logic [bcad_pkg::BLOCK_W-1:0]          alpha_texels_high;
    logic                                  not_opaque;

    modport source (output valid, output alpha_texels_low, output alpha_texels_high,
                    output not_opaque, input ready);
    modport sink   (input valid, input alpha_texels_low, input alpha_texels_high,
                    input not_opaque, output ready);
endinterface

// ----- rtl/bc_alpha_block_decoder.sv -----
// An accepted item passes through the input register, then the result register,
//   before its result is presented with texels.valid high.
// Throughput: one item per cycle; the input side stalls only while both
//   registers are full and the result is not taken.
// Reset (rst_n low, asynchronous): both stages empty, mode_reg = 1 (interpolated).
module bc_alpha_block_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    bcad_in_if.sink    block,
    bcad_out_if.source texels
);

    logic                         mode_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [bcad_pkg::BLOCK_W-1:0] s1_block_reg;
    logic                         s2_valid_reg;
    logic                         s2_valid_next;
    logic [bcad_pkg::BLOCK_W-1:0] lo_reg;
    logic [bcad_pkg::BLOCK_W-1:0] hi_reg;
    logic                         no_reg;

    logic                         advance;
    logic                         accept;
    bcad_pkg::ramp_t              ramp;
    bcad_pkg::texels_t            alpha;
    logic                         translucent;

    assign advance     = !s2_valid_reg || texels.ready;
    assign block.ready = !s1_valid_reg || advance;
    assign accept      = block.valid && block.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bcad_pkg::MODE_RESET;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        ramp = bcad_pkg::build_ramp(s1_block_reg[7:0], s1_block_reg[15:8]);
        for (int t = 0; t < bcad_pkg::TEXELS; t++)
        begin
            if (mode_reg == bcad_pkg::MODE_EXPLICIT)
            begin
                alpha[t] = {2{s1_block_reg[4*t +: 4]}};
            end
            else
            begin
                alpha[t] = ramp[s1_block_reg[16 + 3*t +: 3]];
            end
        end
        translucent = !(&alpha);
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_block_reg <= block.alpha_block;
        end
        if (advance && s1_valid_reg)
        begin
            lo_reg <= alpha[7:0];
            hi_reg <= alpha[15:8];
            no_reg <= translucent;
        end
    end

    assign texels.valid             = s2_valid_reg;
    assign texels.alpha_texels_low  = lo_reg;
    assign texels.alpha_texels_high = hi_reg;
    assign texels.not_opaque        = no_reg;

endmodule

// ----- rtl/bcad_checker.sv -----
`include "bc_alpha_block_decoder_macros.svh"

module bcad_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_we,
    input logic                         cfg_wdata,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bcad_pkg::BLOCK_W-1:0] out_low,
    input logic [bcad_pkg::BLOCK_W-1:0] out_high,
    input logic                         out_not_opaque
);

    logic mode_reg;
    logic nibbles_match;
    logic all_opaque;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bcad_pkg::MODE_RESET;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // explicit alphas are nibble * 17, so both halves of each byte agree
    always_comb
    begin
        nibbles_match = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (out_low[8*i +: 4] != out_low[8*i+4 +: 4])
            begin
                nibbles_match = 1'b0;
            end
            if (out_high[8*i +: 4] != out_high[8*i+4 +: 4])
            begin
                nibbles_match = 1'b0;
            end
        end
        all_opaque = (&out_low) && (&out_high);
    end

    `BCAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_low) && $stable(out_high) && $stable(out_not_opaque))
    `BCAD_ASSERT_NOW(a_flag_matches, clk, rst_n, out_valid, out_not_opaque == !all_opaque)
    `BCAD_ASSERT_NOW(a_explicit_scale, clk, rst_n, out_valid && (mode_reg == bcad_pkg::MODE_EXPLICIT), nibbles_match)
    `BCAD_ASSERT_NOW(a_ready_when_drained, clk, rst_n, !out_valid, in_ready)

endmodule

bind bc_alpha_block_decoder bcad_checker u_bcad_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ready       (block.ready),
    .out_valid      (texels.valid),
    .out_ready      (texels.ready),
    .out_low        (texels.alpha_texels_low),
    .out_high       (texels.alpha_texels_high),
    .out_not_opaque (texels.not_opaque)
);

// ----- tb/sv/bc_alpha_block_decoder_test.sv -----
module bc_alpha_block_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int PHASE_ITEMS    = 60;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_LIMIT   = 10;

    // index of texel t is t mod 8, so every ramp entry is selected twice
    localparam logic [47:0] EVERY_INDEX = {24'o76543210, 24'o76543210};

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
        logic        not_opaque;
    } texel_result_t;

    class texel_scoreboard;
        texel_result_t pending_texels[$];
        int unsigned   mismatches;
        int unsigned   checked;
        int unsigned   per_mode[2];
        int unsigned   opaque_seen;

        function texel_result_t decode_alpha(logic [63:0] blk, logic mode);
            texel_result_t     res;
            bcad_pkg::texels_t tx;
            int unsigned       ramp[8];
            int unsigned       a0;
            int unsigned       a1;
            int unsigned       a;
            a0      = blk[7:0];
            a1      = blk[15:8];
            ramp[0] = a0;
            ramp[1] = a1;
            if (a0 > a1)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    ramp[2 + i] = ((6 - i) * a0 + (1 + i) * a1) / 7;
                end
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ramp[2 + i] = ((4 - i) * a0 + (1 + i) * a1) / 5;
                end
                ramp[6] = bcad_pkg::ALPHA_MIN;
                ramp[7] = bcad_pkg::ALPHA_MAX;
            end
            res.not_opaque = 1'b0;
            for (int t = 0; t < 16; t++)
            begin
                if (mode == bcad_pkg::MODE_EXPLICIT)
                begin
                    a = int'(blk[4 * t +: 4]) * 255 / 15;
                end
                else
                begin
                    a = ramp[blk[16 + 3 * t +: 3]];
                end
                tx[t] = a[7:0];
                if (a[7:0] < bcad_pkg::ALPHA_MAX)
                begin
                    res.not_opaque = 1'b1;
                end
            end
            {res.high, res.low} = tx;
            return res;
        endfunction

        function void note_block(logic [63:0] blk, logic mode);
            pending_texels.push_back(decode_alpha(blk, mode));
            per_mode[mode]++;
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("mismatch in %s: expected %h, got %h", field, want, got);
            end
        endfunction

        function void check_texels(texel_result_t got);
            texel_result_t want;
            if (pending_texels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("texel result with no block pending: low %h high %h",
                             got.low, got.high);
                end
                return;
            end
            want = pending_texels.pop_front();
            checked++;
            if (!want.not_opaque)
            begin
                opaque_seen++;
            end
            if (got.low !== want.low)
            begin
                report("alpha_texels_low", want.low, got.low);
            end
            if (got.high !== want.high)
            begin
                report("alpha_texels_high", want.high, got.high);
            end
            if (got.not_opaque !== want.not_opaque)
            begin
                report("not_opaque", 64'(want.not_opaque), 64'(got.not_opaque));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic alpha_mode_shadow;
    int   send_idle   = 0;
    int   recv_stall  = 0;
    int   hold_left   = 0;
    int   quiet_count = 0;
    int   mode_writes = 0;

    int send_profile[4] = '{0, 59, 0, 8};
    int recv_profile[4] = '{0, 0, 59, 8};

    texel_scoreboard sb = new();

    bcad_in_if  block_if();
    bcad_out_if texels_if();

    bc_alpha_block_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .block     (block_if),
        .texels    (texels_if)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (block_if.valid && block_if.ready)
            begin
                sb.note_block(block_if.alpha_block, alpha_mode_shadow);
            end
            if (texels_if.valid && texels_if.ready)
            begin
                sb.check_texels('{texels_if.alpha_texels_low, texels_if.alpha_texels_high,
                                  texels_if.not_opaque});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (block_if.valid && block_if.ready) ||
            (texels_if.valid && texels_if.ready))
        begin
            quiet_count = 0;
        end
        else
        begin
            quiet_count++;
        end
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", quiet_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, or a counted hold-off when requested
    initial
    begin
        texels_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                texels_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                texels_if.ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    function automatic logic [63:0] random_block(input logic mode);
        logic [63:0] blk;
        logic [7:0]  a0;
        logic [7:0]  a1;
        blk = {$urandom, $urandom};
        if (mode == bcad_pkg::MODE_EXPLICIT)
        begin
            case ($urandom_range(7))
                0: blk = '1;
                1: blk = ~(64'h1 << $urandom_range(63));
                default: ;
            endcase
        end
        else
        begin
            a0 = blk[7:0];
            a1 = blk[15:8];
            case ($urandom_range(7))
                0: a1 = a0;
                1: a0 = bcad_pkg::ALPHA_MAX;
                2: a1 = bcad_pkg::ALPHA_MIN;
                3:
                begin
                    a0         = bcad_pkg::ALPHA_MAX;
                    a1         = bcad_pkg::ALPHA_MAX;
                    blk[63:16] = '0;
                end
                4: blk[63:16] = {16{3'd7}};
                default: ;
            endcase
            blk[15:0] = {a1, a0};
        end
        return blk;
    endfunction

    task automatic send_block(input logic [63:0] blk);
        while ($urandom_range(99) < send_idle)
        begin
            block_if.valid <= 1'b0;
            @(negedge clk);
        end
        block_if.valid       <= 1'b1;
        block_if.alpha_block <= blk;
        do
        begin
            @(posedge clk);
        end
        while (!block_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        block_if.valid <= 1'b0;
        while (sb.pending_texels.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we            <= 1'b0;
        alpha_mode_shadow = mode;
        mode_writes++;
    endtask

    task automatic run_phase(input logic mode, input int profile, input bit hold_off,
                             input bit pause);
        write_mode(mode);
        send_idle  = send_profile[profile];
        recv_stall = recv_profile[profile];
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (hold_off && n == PHASE_ITEMS / 3)
            begin
                hold_left = HOLD_CYCLES;
            end
            if (pause && n == PHASE_ITEMS / 2)
            begin
                wait_drained();
            end
            send_block(random_block(mode));
        end
    endtask

    initial
    begin
        logic [63:0] interp_blocks[$];
        logic [63:0] explicit_blocks[$];
        interp_blocks = '{
            {EVERY_INDEX, 8'd0, 8'd255},
            {EVERY_INDEX, 8'd255, 8'd0},
            {EVERY_INDEX, 8'd128, 8'd128},
            {EVERY_INDEX, 8'd0, 8'd0},
            {EVERY_INDEX, 8'd255, 8'd255},
            {EVERY_INDEX, 8'd0, 8'd1},
            {EVERY_INDEX, 8'd17, 8'd200},
            {48'h0, 8'd255, 8'd255},
            64'hFFFF_FFFF_FFFF_FFFF,
            64'h0
        };
        explicit_blocks = '{
            64'h0,
            64'hFFFF_FFFF_FFFF_FFFF,
            64'hFEDC_BA98_7654_3210,
            64'h5555_5555_5555_5555,
            64'hAAAA_AAAA_AAAA_AAAA
        };
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        block_if.valid       = 1'b0;
        block_if.alpha_block = '0;
        alpha_mode_shadow    = bcad_pkg::MODE_RESET;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (interp_blocks[i])
        begin
            send_block(interp_blocks[i]);
        end
        write_mode(bcad_pkg::MODE_EXPLICIT);
        foreach (explicit_blocks[i])
        begin
            send_block(explicit_blocks[i]);
        end

        for (int p = 0; p < 8; p++)
        begin
            run_phase(p[0] ? bcad_pkg::MODE_EXPLICIT : bcad_pkg::MODE_INTERP, p / 2,
                      p == 0, p == 3);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d blocks checked: %0d explicit, %0d interpolated, %0d fully opaque",
                 sb.checked, sb.per_mode[bcad_pkg::MODE_EXPLICIT],
                 sb.per_mode[bcad_pkg::MODE_INTERP], sb.opaque_seen);
        $display("mode written %0d times; idle, sender, receiver and mixed stalls, %s",
                 mode_writes, "one long result hold-off and one drain pause");
        if (sb.mismatches == 0 && sb.pending_texels.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_texels.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
